@@ src/ufcp_pkg.sv @@
`timescale 1ns / 1ps
package ufcp_pkg;

  typedef enum logic [2:0] {
    KIND_ERROR       = 3'd0,
    KIND_READ        = 3'd1,
    KIND_WRITE       = 3'd2,
    KIND_ERASE_ALL   = 3'd3,
    KIND_ERASE_BLOCK = 3'd4,
    KIND_SEGMENTS    = 3'd5,
    KIND_TIMER       = 3'd6,
    KIND_WRITE_DATA  = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DECIDE,
    ST_MUL,
    ST_HEAD,
    ST_DATA_RD,
    ST_DATA_EMIT,
    ST_COPY
  } state_e;

  typedef enum logic [1:0] {
    REG_BLOCK_BYTES    = 2'd0,
    REG_TICKS_PER_UNIT = 2'd1,
    REG_MAX_PENDING    = 2'd2
  } reg_idx_e;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;

  localparam logic [15:0] BLOCK_BYTES_RST    = 16'd4000;
  localparam logic [19:0] TICKS_PER_UNIT_RST = 20'd100000;
  localparam logic [3:0]  MAX_PENDING_RST    = 4'd5;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       flash_busy;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  addr_or_value;
    logic [6:0]  length;
    logic [23:0] block_offset;
    logic [27:0] timer_ticks;
    logic        periodic;
    logic [7:0]  data_byte;
    logic        last;
  } out_t;

  typedef struct packed {
    logic take;
    logic load;
    logic decide;
    logic set_err;
    logic mul;
    logic emit_head;
    logic emit_data;
    logic copy;
    logic push;
    logic finish;
    logic step_clr;
    logic step_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
    logic term;
    logic full;
    logic pend_avail;
    logic load_done;
    logic flash;
    logic busy;
    logic src_pend;
    logic pend_full;
    logic has_data;
    logic data_last;
    logic copy_done;
    logic out_free;
  } dp_stat_t;

  // 5-bit result, bit 4 set for a non-hex character
  function automatic logic [4:0] hexval(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    return v;
  endfunction

endpackage

@@ src/ufcp_stream_if.sv @@
`timescale 1ns / 1ps
interface ufcp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/ufcp_ram.sv @@
`timescale 1ns / 1ps
module ufcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ src/ufcp_ctrl.sv @@
`timescale 1ns / 1ps
module ufcp_ctrl
  import ufcp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          if (stat_i.mode) begin
            if (stat_i.pend_avail) state_d = ST_LOAD;
          end else if (stat_i.full) begin
            state_d = ST_HEAD;
          end else if (stat_i.term) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (stat_i.load_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.flash && stat_i.busy) begin
          if (stat_i.src_pend) state_d = ST_IDLE;
          else if (stat_i.pend_full) state_d = ST_HEAD;
          else state_d = ST_COPY;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_HEAD;
      ST_HEAD: begin
        if (stat_i.out_free) state_d = stat_i.has_data ? ST_DATA_RD : ST_IDLE;
      end
      ST_DATA_RD: state_d = ST_DATA_EMIT;
      ST_DATA_EMIT: begin
        if (stat_i.out_free) state_d = stat_i.data_last ? ST_IDLE : ST_DATA_RD;
      end
      ST_COPY: begin
        if (stat_i.copy_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take     = fire;
        cmd_o.step_clr = fire;
      end
      ST_LOAD: begin
        cmd_o.load     = 1'b1;
        cmd_o.step_inc = 1'b1;
      end
      ST_DECIDE: begin
        if (stat_i.flash && stat_i.busy) begin
          cmd_o.set_err  = !stat_i.src_pend && stat_i.pend_full;
          cmd_o.step_clr = 1'b1;
        end else begin
          cmd_o.decide = 1'b1;
        end
      end
      ST_MUL: cmd_o.mul = 1'b1;
      ST_HEAD: begin
        if (stat_i.out_free) begin
          cmd_o.emit_head = 1'b1;
          cmd_o.step_clr  = 1'b1;
          cmd_o.finish    = !stat_i.has_data;
        end
      end
      ST_DATA_RD: ;
      ST_DATA_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_data = 1'b1;
          cmd_o.step_inc  = 1'b1;
          cmd_o.finish    = stat_i.data_last;
        end
      end
      ST_COPY: begin
        cmd_o.copy     = 1'b1;
        cmd_o.step_inc = 1'b1;
        cmd_o.push     = stat_i.copy_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ src/ufcp_dp.sv @@
`timescale 1ns / 1ps
module ufcp_dp
  import ufcp_pkg::*;
#(
  parameter int MSG_BYTES     = 64,
  parameter int PENDING_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_t         in_data_i,
  input  logic [15:0] block_bytes_i,
  input  logic [19:0] ticks_per_unit_i,
  input  logic [3:0]  max_pending_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  output logic        out_valid_o,
  output out_t        out_data_o,
  input  logic        out_ready_i
);
  localparam int AW    = $clog2(MSG_BYTES);
  localparam int HW    = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int CW    = $clog2(PENDING_SLOTS + 1);
  localparam int DEPTH = (PENDING_SLOTS + 1) * MSG_BYTES;
  localparam int RW    = $clog2(DEPTH);
  localparam logic [RW-1:0] RX_BASE = RW'(PENDING_SLOTS * MSG_BYTES);
  localparam logic [RW-1:0] MSG_RW  = RW'(MSG_BYTES);

  // control state
  logic [AW-1:0] rx_count_q, rx_count_d;
  logic [HW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;

  // working registers
  logic [AW-1:0]     n_q, step_q;
  logic [RW-1:0]     base_q, dest_base_q;
  logic [HW-1:0]     dest_slot_q;
  logic              src_pend_q, busy_q;
  logic [6:0][7:0]   hdr_q;
  kind_e             kind_q;
  logic [7:0]        av_q;
  logic [6:0]        len_q;
  logic              per_q;
  logic [5:0]        dn_q;
  logic [23:0]       boff_q;
  logic [27:0]       ticks_q;
  logic [AW-1:0]     pend_len_q [PENDING_SLOTS];
  out_t              out_q;

  logic              ram_we;
  logic [RW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic [AW:0]       new_cnt;
  logic              full, term;
  logic [CW:0]       dest_sum;
  logic [HW-1:0]     dest_slot, head_inc;
  logic [2:0]        hdr_idx;
  logic [AW-1:0]     step_m1;

  logic [4:0]        hx2, hx3, hx4, hx5;
  logic              ok2, ok3, ok4, ok5;
  logic [7:0]        hb2, hb4;
  logic              is_rf, is_wf, is_ef, is_eb, is_ss, is_st;
  logic [AW-1:0]     wcnt;

  kind_e             dec_kind;
  logic [7:0]        dec_av;
  logic [6:0]        dec_len;
  logic              dec_per;
  logic [5:0]        dec_dn;

  ufcp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign new_cnt = {1'b0, rx_count_q} + (AW + 1)'(1);
  assign full    = (new_cnt == (AW + 1)'(MSG_BYTES));
  assign term    = (in_data_i.rx_byte == CH_DOT);
  assign step_m1 = step_q - AW'(1);
  assign hdr_idx = step_m1[2:0];

  // next free slot of the ring
  assign dest_sum  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
  assign dest_slot = (dest_sum >= (CW + 1)'(PENDING_SLOTS)) ?
                     HW'(dest_sum - (CW + 1)'(PENDING_SLOTS)) : HW'(dest_sum);
  assign head_inc  = (32'(head_q) == PENDING_SLOTS - 1) ? '0 : head_q + HW'(1);

  // command classification
  assign hx2 = hexval(hdr_q[2]);
  assign hx3 = hexval(hdr_q[3]);
  assign hx4 = hexval(hdr_q[4]);
  assign hx5 = hexval(hdr_q[5]);
  assign ok2 = !hx2[4];
  assign ok3 = !hx3[4];
  assign ok4 = !hx4[4];
  assign ok5 = !hx5[4];
  assign hb2 = {hx2[3:0], hx3[3:0]};
  assign hb4 = {hx4[3:0], hx5[3:0]};
  assign wcnt = n_q - AW'(5);

  assign is_rf = hdr_q[0] == CH_R && hdr_q[1] == CH_F && ok2 && ok3 && ok4 && ok5 &&
                 hdr_q[6] == CH_DOT;
  assign is_wf = hdr_q[0] == CH_W && hdr_q[1] == CH_F && ok2 && ok3 && n_q >= AW'(5);
  assign is_ef = hdr_q[0] == CH_E && hdr_q[1] == CH_F && hdr_q[2] == CH_DOT;
  assign is_eb = hdr_q[0] == CH_E && hdr_q[1] == CH_B && ok2 && ok3 && hdr_q[4] == CH_DOT;
  assign is_ss = hdr_q[0] == CH_S && hdr_q[1] == CH_S && ok2 && ok3 && hdr_q[4] == CH_DOT;
  assign is_st = hdr_q[0] == CH_S && hdr_q[1] == CH_T && ok2 && ok3 &&
                 (hdr_q[4] == CH_0 || hdr_q[4] == CH_1) && hdr_q[5] == CH_DOT;

  always_comb begin
    dec_kind = KIND_ERROR;
    dec_av   = '0;
    dec_len  = '0;
    dec_per  = 1'b0;
    dec_dn   = '0;
    if (is_rf) begin
      dec_kind = KIND_READ;
      dec_av   = hb2;
      dec_len  = hb4[6:0];
    end else if (is_wf) begin
      dec_kind = KIND_WRITE;
      dec_av   = hb2;
      dec_len  = 7'(wcnt);
      // data run capped so the whole run stays within 64 results
      dec_dn   = (32'(wcnt) > 63) ? 6'd63 : 6'(wcnt);
    end else if (is_ef) begin
      dec_kind = KIND_ERASE_ALL;
    end else if (is_eb) begin
      dec_kind = KIND_ERASE_BLOCK;
      dec_av   = hb2;
    end else if (is_ss) begin
      dec_kind = KIND_SEGMENTS;
      dec_av   = hb2;
    end else if (is_st) begin
      dec_kind = KIND_TIMER;
      dec_av   = hb2;
      dec_per  = (hdr_q[4] == CH_1);
    end
  end

  // memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = RX_BASE + RW'(rx_count_q);
    ram_wdata = in_data_i.rx_byte;
    if (cmd_i.take && !in_data_i.mode) begin
      ram_we = 1'b1;
    end else if (cmd_i.copy && step_q != '0) begin
      ram_we    = 1'b1;
      ram_waddr = dest_base_q + RW'(step_m1);
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    if (cmd_i.copy) ram_raddr = RX_BASE + RW'(step_q);
    else if (cmd_i.load) ram_raddr = base_q + RW'(step_q);
    else ram_raddr = base_q + RW'(4) + RW'(step_q);
  end

  assign stat_o.mode       = in_data_i.mode;
  assign stat_o.term       = term;
  assign stat_o.full       = full;
  assign stat_o.pend_avail = (count_q != '0);
  assign stat_o.load_done  = (step_q == AW'(7));
  assign stat_o.flash      = is_rf || is_wf || is_ef || is_eb;
  assign stat_o.busy       = busy_q;
  assign stat_o.src_pend   = src_pend_q;
  assign stat_o.pend_full  = (32'(count_q) >= PENDING_SLOTS) ||
                             (32'(count_q) >= 32'(max_pending_i));
  assign stat_o.has_data   = (dn_q != '0);
  assign stat_o.data_last  = (32'(step_q) == 32'(dn_q) - 1);
  assign stat_o.copy_done  = (step_q == n_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    rx_count_d  = rx_count_q;
    head_d      = head_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.emit_head || cmd_i.emit_data) out_valid_d = 1'b1;
    if (cmd_i.take && !in_data_i.mode) begin
      rx_count_d = (full || term) ? '0 : new_cnt[AW-1:0];
    end
    if (cmd_i.finish && src_pend_q) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
    if (cmd_i.push) count_d = count_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q  <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rx_count_q  <= rx_count_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_clr) step_q <= '0;
    else if (cmd_i.step_inc) step_q <= step_q + AW'(1);

    if (cmd_i.take) begin
      busy_q      <= in_data_i.flash_busy;
      src_pend_q  <= in_data_i.mode;
      dest_slot_q <= dest_slot;
      dest_base_q <= RW'(dest_slot) * MSG_RW;
      if (in_data_i.mode) begin
        n_q    <= pend_len_q[head_q];
        base_q <= RW'(head_q) * MSG_RW;
      end else begin
        n_q    <= new_cnt[AW-1:0];
        base_q <= RX_BASE;
      end
    end

    if (cmd_i.load && step_q != '0) begin
      hdr_q[hdr_idx] <= (step_m1 < n_q) ? ram_rdata : 8'h00;
    end

    if ((cmd_i.take && !in_data_i.mode && full) || cmd_i.set_err) begin
      kind_q  <= KIND_ERROR;
      av_q    <= '0;
      len_q   <= '0;
      per_q   <= 1'b0;
      dn_q    <= '0;
      boff_q  <= '0;
      ticks_q <= '0;
    end else if (cmd_i.decide) begin
      kind_q <= dec_kind;
      av_q   <= dec_av;
      len_q  <= dec_len;
      per_q  <= dec_per;
      dn_q   <= dec_dn;
    end

    if (cmd_i.mul) begin
      boff_q  <= (kind_q == KIND_ERASE_BLOCK) ? av_q * block_bytes_i : '0;
      ticks_q <= (kind_q == KIND_TIMER) ? av_q * ticks_per_unit_i : '0;
    end

    if (cmd_i.push) pend_len_q[dest_slot_q] <= n_q;

    if (cmd_i.emit_head) begin
      out_q.kind          <= kind_q;
      out_q.addr_or_value <= av_q;
      out_q.length        <= len_q;
      out_q.block_offset  <= boff_q;
      out_q.timer_ticks   <= ticks_q;
      out_q.periodic      <= per_q;
      out_q.data_byte     <= '0;
      out_q.last          <= (dn_q == '0);
    end else if (cmd_i.emit_data) begin
      out_q.kind          <= KIND_WRITE_DATA;
      out_q.addr_or_value <= '0;
      out_q.length        <= '0;
      out_q.block_offset  <= '0;
      out_q.timer_ticks   <= '0;
      out_q.periodic      <= 1'b0;
      out_q.data_byte     <= ram_rdata;
      out_q.last          <= stat_o.data_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

@@ src/uart_flash_command_parser.sv @@
`timescale 1ns / 1ps
// UART flash command parser.
// in_if carries one beat per received byte (mode 0) or flash-done event (mode 1),
// with the current flash_busy level. out_if carries result beats; the final
// beat caused by an input has last set. Registers sit on the APB port:
// block_bytes at 0x0, ticks_per_unit at 0x4, max_pending at 0x8.
// A plain byte is taken without leaving idle. A '.' or a retried request first
// reads its seven header bytes from the message RAM, then decodes, forms
// products and loads the output register. Each write data byte then takes a
// RAM read and an output load. A busy flash command is instead copied into its
// pending slot at one byte a cycle.
// The output register frees as its beat is taken; when the receiver stalls the
// sequencer waits and in_if.ready stays low until the run is done.
// Reset empties the receive buffer and the pending ring and loads the register
// defaults; RAM contents are not cleared, none are read before written.
module uart_flash_command_parser
  import ufcp_pkg::*;
#(
  parameter int MSG_BYTES     = 64,
  parameter int PENDING_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ufcp_stream_if.sink   in_if,
  ufcp_stream_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] block_bytes_q;
  logic [19:0] ticks_per_unit_q;
  logic [3:0]  max_pending_q;
  logic        cfg_we;
  reg_idx_e    reg_sel;
  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic        in_ready;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q    <= BLOCK_BYTES_RST;
      ticks_per_unit_q <= TICKS_PER_UNIT_RST;
      max_pending_q    <= MAX_PENDING_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_BLOCK_BYTES:    block_bytes_q    <= pwdata[15:0];
        REG_TICKS_PER_UNIT: ticks_per_unit_q <= pwdata[19:0];
        REG_MAX_PENDING:    max_pending_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BLOCK_BYTES:    prdata = {16'h0, block_bytes_q};
      REG_TICKS_PER_UNIT: prdata = {12'h0, ticks_per_unit_q};
      REG_MAX_PENDING:    prdata = {28'h0, max_pending_q};
      default:            prdata = '0;
    endcase
  end

  ufcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ufcp_dp #(
    .MSG_BYTES     (MSG_BYTES),
    .PENDING_SLOTS (PENDING_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_data_i        (in_if.data),
    .block_bytes_i    (block_bytes_q),
    .ticks_per_unit_i (ticks_per_unit_q),
    .max_pending_i    (max_pending_q),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_if.valid),
    .out_data_o       (out_if.data),
    .out_ready_i      (out_if.ready)
  );

  assign in_if.ready = in_ready;

  // a retried request keeps the input closed while it is decoded
  a_retry_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_ready && in_if.data.mode && stat.pend_avail) |=> !in_ready)
    else $error("input open during pending retry");

  // a plain byte returns straight to idle
  a_plain_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_ready && !in_if.data.mode && !stat.full && !stat.term)
      |=> in_ready)
    else $error("plain byte did not return to idle");

  // a head beat is only loaded while the sequencer is away from idle
  a_head_only_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_head |-> !in_ready)
    else $error("result loaded while idle");
endmodule

@@ tb/tb_uart_flash_command_parser.sv @@
`timescale 1ns / 1ps
module tb_uart_flash_command_parser;
  import ufcp_pkg::*;

  localparam int MSG_LEN   = 64;
  localparam int SLOTS     = 8;
  localparam int CYC_LIMIT = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  ufcp_stream_if #(.payload_t(in_t))  in_if ();
  ufcp_stream_if #(.payload_t(out_t)) out_if ();

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  uart_flash_command_parser dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [15:0] m_blk_bytes;
  logic [19:0] m_ticks;
  logic [3:0]  m_max_pend;
  logic [7:0]  m_rxbuf [MSG_LEN];
  int          m_rxcnt;
  logic [7:0]  m_pstore [SLOTS][MSG_LEN];
  int          m_plen [SLOTS];
  int          m_phead, m_pcnt;

  out_t expected_q[$];
  out_t step_res[$];

  int     n_mismatch = 0;
  int     n_results = 0;
  int     n_beats_sent = 0;
  int     cycles = 0;
  bit     stall_en = 1'b1;

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return 5'h10;
  endfunction

  function automatic void push_res(kind_e k, logic [7:0] av, logic [6:0] len,
                                   logic [23:0] boff, logic [27:0] tk,
                                   logic per, logic [7:0] db);
    out_t r;
    if (step_res.size() >= 64) return;
    r = '0;
    r.kind = k; r.addr_or_value = av; r.length = len; r.block_offset = boff;
    r.timer_ticks = tk; r.periodic = per; r.data_byte = db;
    step_res.push_back(r);
  endfunction

  // decode a request; returns 0 when it must wait for the flash
  function automatic bit decode_request(logic [7:0] b[MSG_LEN], int n, bit busy);
    logic [7:0] c[8];
    logic [4:0] nb[8];
    bit         hx[8];
    logic [7:0] hb2, hb4;
    int         cnt;
    for (int i = 0; i < 8; i++) begin
      c[i] = (i < n) ? b[i] : 8'h00;
      nb[i] = nibble_of(c[i]);
      hx[i] = !nb[i][4];
    end
    hb2 = {nb[2][3:0], nb[3][3:0]};
    hb4 = {nb[4][3:0], nb[5][3:0]};
    if (c[0] == CH_R && c[1] == CH_F && hx[2] && hx[3] && hx[4] && hx[5] && c[6] == CH_DOT) begin
      if (busy) return 0;
      push_res(KIND_READ, hb2, hb4[6:0], '0, '0, 0, '0);
    end else if (c[0] == CH_W && c[1] == CH_F && hx[2] && hx[3] && n >= 5) begin
      if (busy) return 0;
      cnt = n - 5;
      push_res(KIND_WRITE, hb2, 7'(cnt), '0, '0, 0, '0);
      for (int i = 0; i < cnt && step_res.size() < 64; i++)
        push_res(KIND_WRITE_DATA, '0, '0, '0, '0, 0, b[4 + i]);
    end else if (c[0] == CH_E && c[1] == CH_F && c[2] == CH_DOT) begin
      if (busy) return 0;
      push_res(KIND_ERASE_ALL, '0, '0, '0, '0, 0, '0);
    end else if (c[0] == CH_E && c[1] == CH_B && hx[2] && hx[3] && c[4] == CH_DOT) begin
      if (busy) return 0;
      push_res(KIND_ERASE_BLOCK, hb2, '0, 24'(hb2) * m_blk_bytes, '0, 0, '0);
    end else if (c[0] == CH_S && c[1] == CH_S && hx[2] && hx[3] && c[4] == CH_DOT) begin
      push_res(KIND_SEGMENTS, hb2, '0, '0, '0, 0, '0);
    end else if (c[0] == CH_S && c[1] == CH_T && hx[2] && hx[3] &&
                 (c[4] == CH_0 || c[4] == CH_1) && c[5] == CH_DOT) begin
      push_res(KIND_TIMER, hb2, '0, '0, 28'(hb2) * m_ticks, c[4] == CH_1, '0);
    end else begin
      push_res(KIND_ERROR, '0, '0, '0, '0, 0, '0);
    end
    return 1;
  endfunction

  function automatic void predict_beat(in_t it);
    int         slot, lim;
    logic [7:0] tmp[MSG_LEN];
    step_res.delete();
    if (it.mode) begin
      if (m_pcnt > 0) begin
        slot = m_phead;
        tmp = m_pstore[slot];
        if (decode_request(tmp, m_plen[slot], it.flash_busy)) begin
          m_phead = (m_phead + 1) % SLOTS;
          m_pcnt--;
        end
      end
    end else begin
      if (m_rxcnt >= MSG_LEN) m_rxcnt = 0;
      m_rxbuf[m_rxcnt++] = it.rx_byte;
      if (m_rxcnt == MSG_LEN) begin
        push_res(KIND_ERROR, '0, '0, '0, '0, 0, '0);
        m_rxcnt = 0;
      end else if (it.rx_byte == CH_DOT) begin
        if (!decode_request(m_rxbuf, m_rxcnt, it.flash_busy)) begin
          lim = (m_max_pend > SLOTS) ? SLOTS : m_max_pend;
          if (m_pcnt >= lim) begin
            push_res(KIND_ERROR, '0, '0, '0, '0, 0, '0);
          end else begin
            slot = (m_phead + m_pcnt) % SLOTS;
            for (int i = 0; i < m_rxcnt; i++) m_pstore[slot][i] = m_rxbuf[i];
            m_plen[slot] = m_rxcnt;
            m_pcnt++;
          end
        end
        m_rxcnt = 0;
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_q.push_back(step_res[i]);
  endfunction

  // idle/stall decision: ~37 in 100 unless disabled
  function automatic bit take_gap();
    return stall_en && ($urandom_range(99) < 37);
  endfunction

  // valid stays high between back-to-back beats; it drops only for a gap
  task automatic send_beat(bit md, logic [7:0] byte_v, bit busy);
    in_t it;
    it.mode = md; it.rx_byte = byte_v; it.flash_busy = busy;
    if (take_gap()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while (take_gap()) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_beat(it);
    n_beats_sent++;
  endtask

  task automatic send_text(string s, bit busy);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i], busy);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    // a copy into the pending ring may still run
    repeat (100) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BLOCK_BYTES:    m_blk_bytes = val[15:0];
      REG_TICKS_PER_UNIT: m_ticks     = val[19:0];
      default:            m_max_pend  = val[3:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [15:0] bb, logic [19:0] tp, logic [3:0] mp);
    wait_drain();
    reg_write(REG_BLOCK_BYTES, 32'(bb));
    reg_write(REG_TICKS_PER_UNIT, 32'(tp));
    reg_write(REG_MAX_PENDING, 32'(mp));
  endtask

  // output side: random stall, check each beat
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result beat %p", out_if.data);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_if.data !== exp_r) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result mismatch: expected %p actual %p", exp_r, out_if.data);
          end
        end
      end
      out_if.ready <= !take_gap();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] hex_ch(logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return ($urandom_range(1)) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  task automatic send_hex(logic [7:0] v, bit busy);
    send_beat(1'b0, hex_ch(v[7:4]), busy);
    send_beat(1'b0, hex_ch(v[3:0]), busy);
  endtask

  task automatic send_random_command(bit busy);
    int         op, n;
    logic [7:0] b;
    op = $urandom_range(7);
    case (op)
      0: begin
        send_text("RF", busy); send_hex(8'($urandom), busy); send_hex(8'($urandom), busy);
      end
      1: begin
        send_text("WF", busy); send_hex(8'($urandom), busy);
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom);
          if (b == CH_DOT) b = 8'hAE;
          send_beat(1'b0, b, busy);
        end
      end
      2: send_text("EF", busy);
      3: begin send_text("EB", busy); send_hex(8'($urandom), busy); end
      4: begin send_text("SS", busy); send_hex(8'($urandom), busy); end
      5: begin
        send_text("ST", busy); send_hex(8'($urandom), busy);
        send_beat(1'b0, $urandom_range(1) ? CH_1 : CH_0, busy);
      end
      6: begin // noise
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) send_beat(1'b0, 8'($urandom), busy);
      end
      default: begin // broken prefix
        send_beat(1'b0, $urandom_range(1) ? CH_R : CH_S, busy);
        send_beat(1'b0, 8'($urandom), busy);
      end
    endcase
    send_beat(1'b0, CH_DOT, busy);
  endtask

  task automatic test_directed_commands();
    send_text("RF00FF.", 0);
    send_text("RFffa0.", 0);
    send_text("WF7e.", 0);
    send_text("WF12ab.", 0);
    send_text("EF.", 0);
    send_text("EBFF.", 0);
    send_text("SS5a.", 0);
    send_text("STff1.", 0);
    send_text("ST010.", 0);
    send_text("ST012.", 0);
    send_text("XY.", 0);
    send_text(".", 0);
  endtask

  task automatic test_overlong();
    for (int i = 0; i < 63; i++) send_beat(1'b0, 8'h41, 0);
    send_beat(1'b0, CH_DOT, 0);
    send_text("WF00", 0);
    for (int i = 0; i < 58; i++) send_beat(1'b0, 8'($urandom), 0);
    send_beat(1'b0, CH_DOT, 0);
  endtask

  task automatic test_pending_ring();
    send_beat(1'b1, 8'h00, 0); // done with nothing held
    for (int i = 0; i < 7; i++) send_text("EB0a.", 1);
    send_text("SS11.", 1);
    send_beat(1'b1, 8'h00, 1);
    for (int i = 0; i < 7; i++) send_beat(1'b1, 8'hFF, 0);
    wait_drain(); // sender holds until every result is back
  endtask

  task automatic test_random_traffic(int n_cmds);
    int r;
    for (int i = 0; i < n_cmds; i++) begin
      stall_en = !(i >= n_cmds / 3 && i < n_cmds / 3 + 15);
      r = $urandom_range(9);
      if (r < 2) send_beat(1'b1, 8'($urandom), $urandom_range(3) == 0);
      else send_random_command($urandom_range(2) == 0);
    end
    stall_en = 1'b1;
  endtask

  initial begin
    m_blk_bytes = BLOCK_BYTES_RST;
    m_ticks = TICKS_PER_UNIT_RST;
    m_max_pend = MAX_PENDING_RST;
    m_rxcnt = 0; m_phead = 0; m_pcnt = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_commands();
    test_overlong();
    test_pending_ring();
    set_config(16'hFFFF, 20'hFFFFF, 4'd8);
    test_random_traffic(10);
    set_config(16'd1, 20'd1, 4'd1);
    test_pending_ring();
    test_random_traffic(8);
    set_config(16'd4000, 20'd100000, 4'd0);
    test_random_traffic(8);
    set_config(16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1048575)), 4'd15);
    test_random_traffic(10);
    wait_drain();

    $display("Sent %0d input beats over five register settings; checked %0d result beats.",
             n_beats_sent, n_results);
    $display("Covered all six commands, malformed and overlong requests, pending ring.");
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_mismatch, expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
